// ----- rtl/tksb_pkg.sv -----
// Shared types, constants and controller/datapath interface structs for take_k_smallest_buffer.
package tksb_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int MAX_TAKE_DEF = 20;

    localparam int VALUE_W    = 31;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_TK_NEXT,
        ST_TK_GRAB,
        ST_TK_EMIT,
        ST_DN_RD,
        ST_DN_CMP
    } t_state;

    typedef struct packed {
        logic ins_start;
        logic take_start;
        logic up_read;
        logic up_move;
        logic wr_x;
        logic root_read;
        logic grab;
        logic emit_val;
        logic emit_pad;
        logic down_read;
        logic down_move;
    } t_cmd;

    typedef struct packed {
        logic in_insert;
        logic in_cnt_zero;
        logic full;
        logic empty;
        logic idx_zero;
        logic up_less;
        logic has_left;
        logic down_stop;
        logic out_free;
        logic rem_one;
        logic rem_zero;
    } t_status;

endpackage

// ----- rtl/tksb_ctrl.sv -----
// Controller state machine that sequences heap inserts, pops and result emission.
module tksb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tksb_pkg::t_status i_status,
    output tksb_pkg::t_cmd    o_cmd
);

    tksb_pkg::t_state r_state;
    tksb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tksb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            tksb_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_status.in_insert) begin
                        // drop an insert into a full store
                        if (!i_status.full) begin
                            o_cmd.ins_start = 1'b1;
                            n_state         = tksb_pkg::ST_INS_CHK;
                        end
                    end else if (!i_status.in_cnt_zero) begin
                        o_cmd.take_start = 1'b1;
                        n_state          = tksb_pkg::ST_TK_NEXT;
                    end
                end
            end
            tksb_pkg::ST_INS_CHK: begin
                if (i_status.idx_zero) begin
                    o_cmd.wr_x = 1'b1;
                    n_state    = tksb_pkg::ST_IDLE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = tksb_pkg::ST_INS_CMP;
                end
            end
            tksb_pkg::ST_INS_CMP: begin
                if (i_status.up_less) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = tksb_pkg::ST_INS_CHK;
                end else begin
                    o_cmd.wr_x = 1'b1;
                    n_state    = tksb_pkg::ST_IDLE;
                end
            end
            tksb_pkg::ST_TK_NEXT: begin
                if (i_status.empty) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_pad = 1'b1;
                        if (i_status.rem_one) begin
                            n_state = tksb_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    o_cmd.root_read = 1'b1;
                    n_state         = tksb_pkg::ST_TK_GRAB;
                end
            end
            tksb_pkg::ST_TK_GRAB: begin
                o_cmd.grab = 1'b1;
                n_state    = tksb_pkg::ST_TK_EMIT;
            end
            tksb_pkg::ST_TK_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_val = 1'b1;
                    n_state        = tksb_pkg::ST_DN_RD;
                end
            end
            tksb_pkg::ST_DN_RD: begin
                if (!i_status.has_left) begin
                    o_cmd.wr_x = 1'b1;
                    n_state    = i_status.rem_zero ? tksb_pkg::ST_IDLE : tksb_pkg::ST_TK_NEXT;
                end else begin
                    o_cmd.down_read = 1'b1;
                    n_state         = tksb_pkg::ST_DN_CMP;
                end
            end
            tksb_pkg::ST_DN_CMP: begin
                if (i_status.down_stop) begin
                    o_cmd.wr_x = 1'b1;
                    n_state    = i_status.rem_zero ? tksb_pkg::ST_IDLE : tksb_pkg::ST_TK_NEXT;
                end else begin
                    o_cmd.down_move = 1'b1;
                    n_state         = tksb_pkg::ST_DN_RD;
                end
            end
            default: begin
                n_state = tksb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tksb_dp.sv -----
// Datapath: heap memory, held count, sift index, remaining-take counter and output register.
module tksb_dp #(
    parameter int CAPACITY = tksb_pkg::CAPACITY_DEF,
    parameter int MAX_TAKE = tksb_pkg::MAX_TAKE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_opcode,
    input  logic [tksb_pkg::VALUE_W-1:0] i_value,
    input  logic [tksb_pkg::COUNT_W-1:0] i_take_count,
    input  tksb_pkg::t_cmd               i_cmd,
    output tksb_pkg::t_status            o_status,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [tksb_pkg::VALUE_W-1:0] o_out_value,
    output logic                         o_out_filled,
    output logic                         o_out_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;
    localparam int RW = $clog2(MAX_TAKE + 1);

    logic [tksb_pkg::VALUE_W-1:0] r_mem [CAPACITY];
    logic [tksb_pkg::VALUE_W-1:0] r_rd_a;
    logic [tksb_pkg::VALUE_W-1:0] r_rd_b;
    logic [tksb_pkg::VALUE_W-1:0] r_x;
    logic [AW-1:0]                r_idx;
    logic [CW-1:0]                r_held;
    logic [RW-1:0]                r_rem;
    logic                         r_out_valid;
    logic [tksb_pkg::VALUE_W-1:0] r_out_value;
    logic                         r_out_filled;
    logic                         r_out_last;

    logic [AW-1:0]                parent;
    logic [LW-1:0]                left;
    logic [LW-1:0]                right;
    logic [LW-1:0]                held_ext;
    logic                         has_right;
    logic                         pick_right;
    logic [tksb_pkg::VALUE_W-1:0] child_val;
    logic [AW-1:0]                child_idx;
    logic [AW-1:0]                addr_a;
    logic [AW-1:0]                addr_b;
    logic                         rd_en;
    logic                         wr_en;
    logic [tksb_pkg::VALUE_W-1:0] wr_data;
    logic                         out_free;

    // heap index arithmetic
    assign parent     = (r_idx - AW'(1)) >> 1;
    assign left       = LW'({r_idx, 1'b1});
    assign right      = left + LW'(1);
    assign held_ext   = LW'(r_held);
    assign has_right  = right < held_ext;
    assign pick_right = has_right && (r_rd_b < r_rd_a);
    assign child_val  = pick_right ? r_rd_b : r_rd_a;
    assign child_idx  = pick_right ? right[AW-1:0] : left[AW-1:0];
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        addr_a = parent;
        addr_b = '0;
        if (i_cmd.root_read) begin
            addr_a = '0;
            addr_b = AW'(r_held - CW'(1));
        end else if (i_cmd.down_read) begin
            addr_a = left[AW-1:0];
            addr_b = has_right ? right[AW-1:0] : '0;
        end
    end

    // Hold the read data between reads so the root survives until it is emitted.
    assign rd_en = i_cmd.up_read || i_cmd.root_read || i_cmd.down_read;

    always_comb begin
        wr_en   = i_cmd.wr_x || i_cmd.up_move || i_cmd.down_move;
        wr_data = r_x;
        if (i_cmd.up_move) begin
            wr_data = r_rd_a;
        end else if (i_cmd.down_move) begin
            wr_data = child_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_start) begin
            r_x   <= i_value;
            r_idx <= AW'(r_held);
        end else if (i_cmd.up_move) begin
            r_idx <= parent;
        end else if (i_cmd.grab) begin
            r_x   <= r_rd_b;
            r_idx <= '0;
        end else if (i_cmd.down_move) begin
            r_idx <= child_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_rem  <= '0;
        end else begin
            if (i_cmd.ins_start) begin
                r_held <= r_held + CW'(1);
            end else if (i_cmd.grab) begin
                r_held <= r_held - CW'(1);
            end
            if (i_cmd.take_start) begin
                if (32'(i_take_count) > MAX_TAKE) begin
                    r_rem <= RW'(MAX_TAKE);
                end else begin
                    r_rem <= RW'(i_take_count);
                end
            end else if (i_cmd.emit_val || i_cmd.emit_pad) begin
                r_rem <= r_rem - RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_val || i_cmd.emit_pad) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_val || i_cmd.emit_pad) begin
            r_out_value  <= i_cmd.emit_val ? r_rd_a : '0;
            r_out_filled <= i_cmd.emit_val;
            r_out_last   <= r_rem == RW'(1);
        end
    end

    always_comb begin
        o_status.in_insert   = i_opcode == tksb_pkg::OP_INSERT;
        o_status.in_cnt_zero = i_take_count == '0;
        o_status.full        = r_held == CW'(CAPACITY);
        o_status.empty       = r_held == '0;
        o_status.idx_zero    = r_idx == '0;
        o_status.up_less     = r_x < r_rd_a;
        o_status.has_left    = left < held_ext;
        o_status.down_stop   = r_x <= child_val;
        o_status.out_free    = out_free;
        o_status.rem_one     = r_rem == RW'(1);
        o_status.rem_zero    = r_rem == '0;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_filled = r_out_filled;
    assign o_out_last   = r_out_last;

endmodule

// ----- rtl/take_k_smallest_buffer.sv -----
// Top level of take_k_smallest_buffer: stream ports around the heap controller and datapath.
//
// A min-heap of up to CAPACITY 31-bit values held in a memory with two
// registered read ports and one write port. An insert item (tuser 0) stores
// its value and gives no result; an insert into a full store is dropped. A
// take item (tuser 1) emits the take_count smallest values in ascending
// order (count saturates at MAX_TAKE; a count of zero gives nothing),
// removing each, with tlast on the final result. Once the store runs dry the
// remaining results carry 0 in tdata and 0 in tuser (filled). Items are
// handled one at a time. An insert climbs the heap from the free slot: it
// reads the parent, moves it down while the new value is smaller, then
// writes the value in place. A take emits each value result by reading the
// root and the last entry, grabbing the last entry and emitting the root,
// then sifts down: it reads the children, moves the smaller child up while
// it is smaller than the moved value, then writes the moved value in place.
// A padding result needs only the emit. These steps are set by the
// read-compare-write loop over the heap memory; a result that meets a busy
// sink waits in its emit state until the output register frees. The output
// register lets the next item be accepted while the last result still waits
// on the sink. No clearing pass runs after reset: the store is empty and
// entries are only read after they were written.
module take_k_smallest_buffer #(
    parameter int CAPACITY = tksb_pkg::CAPACITY_DEF,
    parameter int MAX_TAKE = tksb_pkg::MAX_TAKE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tksb_pkg::IN_DATA_W-1:0]  i_s_tdata,  // value[30:0], take_count[35:31]
    input  logic                            i_s_tuser,  // opcode: 0 insert, 1 take
    // result item stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tksb_pkg::OUT_DATA_W-1:0] o_m_tdata,  // out_value[30:0]
    output logic                            o_m_tuser,  // filled
    output logic                            o_m_tlast   // last result of a take
);

    tksb_pkg::t_cmd               cmd;
    tksb_pkg::t_status            status;
    logic [tksb_pkg::VALUE_W-1:0] out_value;

    // Controller: accept items in idle and step the heap walk.
    tksb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: heap memory, counters and the result register.
    tksb_dp #(
        .CAPACITY (CAPACITY),
        .MAX_TAKE (MAX_TAKE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_s_tuser),
        .i_value      (i_s_tdata[tksb_pkg::VALUE_W-1:0]),
        .i_take_count (i_s_tdata[tksb_pkg::VALUE_W +: tksb_pkg::COUNT_W]),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_out_value  (out_value),
        .o_out_filled (o_m_tuser),
        .o_out_last   (o_m_tlast)
    );

    // Pad the value up to a whole byte.
    assign o_m_tdata = tksb_pkg::OUT_DATA_W'(out_value);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for take_k_smallest_buffer: inserts and takes checked against a priority-queue predictor.
module tb;

    localparam int VALUE_W    = tksb_pkg::VALUE_W;
    localparam int COUNT_W    = tksb_pkg::COUNT_W;
    localparam int IN_DATA_W  = tksb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = tksb_pkg::OUT_DATA_W;
    // Longest stretch without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to watch for stray results once every expected result has arrived.
    localparam int SETTLE_CYCLES = 64;
    localparam int PAD_W = IN_DATA_W - VALUE_W - COUNT_W;

    // One command item as the sender queues it.
    typedef struct {
        logic               opcode;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] take_count;
        bit                 wait_for_drain;  // hold off until no result is outstanding
    } t_heap_cmd;

    // One result item as the block should produce it.
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               filled;
        logic               last;
    } t_take_result;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    t_heap_cmd          pending_cmds[$];      // commands not yet offered to the block
    t_heap_cmd          cmd_on_bus;           // command currently held on the input bus
    logic [VALUE_W-1:0] held_values[$];       // predicted store contents, unordered
    t_take_result       expected_takes[$];    // results still owed by the block
    int                 cmds_accepted = 0;
    int                 total_cmds    = 0;
    int                 mismatches    = 0;
    int                 stall_cycles  = 0;

    take_k_smallest_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // value[30:0], take_count[35:31], zeros above
        .i_s_tuser  (s_tuser),    // opcode: 0 insert, 1 take
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),  // out_value[30:0], zero above
        .o_m_tuser  (o_m_tuser),  // filled
        .o_m_tlast  (o_m_tlast)   // last result of a take
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Update the predicted store with one accepted command and queue what it owes.
    function automatic void predict_cmd(input t_heap_cmd cmd);
        int           n;
        int           best;
        t_take_result res;
        if (cmd.opcode == tksb_pkg::OP_INSERT) begin
            // drop the value when the store is full
            if (held_values.size() < tksb_pkg::CAPACITY_DEF) begin
                held_values.push_back(cmd.value);
            end
            return;
        end
        // saturate the count; a count of zero owes nothing
        n = (cmd.take_count > tksb_pkg::MAX_TAKE_DEF) ? tksb_pkg::MAX_TAKE_DEF
                                                       : int'(cmd.take_count);
        for (int k = 0; k < n; k++) begin
            res.value  = '0;
            res.filled = 1'b0;
            if (held_values.size() > 0) begin
                best = 0;
                for (int i = 1; i < held_values.size(); i++) begin
                    if (held_values[i] < held_values[best]) begin
                        best = i;
                    end
                end
                res.value  = held_values[best];
                res.filled = 1'b1;
                held_values.delete(best);
            end
            res.last = (k == n - 1);
            expected_takes.push_back(res);
        end
    endfunction

    // Idle percentages per phase: receiver-heavy gaps, then sender-heavy, then none.
    function automatic int sender_idle_pct();
        if (cmds_accepted * 3 < total_cmds) return 35;
        if (cmds_accepted * 3 < total_cmds * 2) return 67;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (cmds_accepted * 3 < total_cmds) return 67;
        if (cmds_accepted * 3 < total_cmds * 2) return 35;
        return 0;
    endfunction

    task automatic queue_cmd(input logic op, input logic [VALUE_W-1:0] val,
                             input logic [COUNT_W-1:0] cnt, input bit hold);
        t_heap_cmd cmd;
        cmd.opcode         = op;
        cmd.value          = val;
        cmd.take_count     = cnt;
        cmd.wait_for_drain = hold;
        pending_cmds.push_back(cmd);
    endtask

    // Mix wide random values with small ones and repeats so that ties occur.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0, 1:    return VALUE_W'($urandom());
            2:       return VALUE_W'($urandom_range(0, 40));
            default: return VALUE_W'($urandom_range(0, 3) * 32'h1555_5555);
        endcase
    endfunction

    // Input driver: hold each item until it is accepted, then advance.
    always @(posedge i_clk) begin : drive_cmds
        t_heap_cmd nxt;
        bit        launch;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                predict_cmd(cmd_on_bus);
                cmds_accepted <= cmds_accepted + 1;
            end
            if (!s_tvalid || o_s_tready) begin
                launch = 1'b0;
                if (pending_cmds.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    launch = !pending_cmds[0].wait_for_drain || expected_takes.size() == 0;
                end
                if (launch) begin
                    nxt        = pending_cmds.pop_front();
                    cmd_on_bus <= nxt;
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {{PAD_W{1'b0}}, nxt.take_count, nxt.value};
                    s_tuser    <= nxt.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_take_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_takes.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: value=%0d filled=%0b last=%0b",
                                 o_m_tdata[VALUE_W-1:0], o_m_tuser, o_m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = expected_takes.pop_front();
                    if (o_m_tdata[VALUE_W-1:0] !== want.value || o_m_tuser !== want.filled ||
                        o_m_tlast !== want.last) begin
                        if (mismatches < 10) begin
                            // value, filled, last on each side
                            $display("mismatch: expected %0d %0b %0b, got %0d %0b %0b",
                                     want.value, want.filled, want.last,
                                     o_m_tdata[VALUE_W-1:0], o_m_tuser, o_m_tlast);
                        end
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int r;
        // Directed: empty takes, zero count, extreme and small values, ties, saturation.
        queue_cmd(tksb_pkg::OP_TAKE, '0, 5'd1, 1'b0);               // padding only
        queue_cmd(tksb_pkg::OP_TAKE, '1, 5'd0, 1'b0);               // count zero gives nothing
        queue_cmd(tksb_pkg::OP_INSERT, 31'h7FFF_FFFF, 5'd31, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'd21, 5'd0, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'd0, 5'd0, 1'b0);          // smallest possible value
        queue_cmd(tksb_pkg::OP_INSERT, 31'd20, 5'd21, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'h5555_5555, 5'h0A, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'h2AAA_AAAA, 5'h15, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'd21, 5'd0, 1'b0);         // duplicate
        queue_cmd(tksb_pkg::OP_TAKE, 31'h7FFF_FFFF, 5'd3, 1'b0);
        queue_cmd(tksb_pkg::OP_TAKE, 31'h2AAA_AAAA, 5'd31, 1'b0);   // saturates, ends in padding
        queue_cmd(tksb_pkg::OP_INSERT, 31'd5, 5'd0, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'd3, 5'd0, 1'b0);
        queue_cmd(tksb_pkg::OP_INSERT, 31'd1, 5'd0, 1'b0);
        queue_cmd(tksb_pkg::OP_TAKE, 31'h5555_5555, 5'd20, 1'b0);
        queue_cmd(tksb_pkg::OP_TAKE, '0, 5'd21, 1'b0);
        queue_cmd(tksb_pkg::OP_TAKE, '0, 5'd1, 1'b0);

        // Random: mostly inserts with takes mixed in, and one pause for a full drain.
        for (int i = 0; i < 80; i++) begin
            if (i == 40) begin
                // pause until every result has come
                queue_cmd(tksb_pkg::OP_INSERT, pick_value(), COUNT_W'($urandom()), 1'b1);
            end
            r = $urandom_range(99);
            if (r < 62) begin
                queue_cmd(tksb_pkg::OP_INSERT, pick_value(), COUNT_W'($urandom()), 1'b0);
            end else if (r < 90) begin
                queue_cmd(tksb_pkg::OP_TAKE, VALUE_W'($urandom()),
                          COUNT_W'($urandom_range(1, 6)), 1'b0);
            end else begin
                queue_cmd(tksb_pkg::OP_TAKE, VALUE_W'($urandom()),
                          COUNT_W'($urandom_range(0, 31)), 1'b0);
            end
        end
        total_cmds = pending_cmds.size();

        // Hold reset, then release it once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all commands to go in and all results to come out, then settle.
        while (pending_cmds.size() > 0 || s_tvalid || expected_takes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- take_k_smallest_buffer.f -----
rtl/tksb_pkg.sv
rtl/tksb_ctrl.sv
rtl/tksb_dp.sv
rtl/take_k_smallest_buffer.sv
dv/tb.sv
